// ===== hdl/lrast_pkg.sv =====
// shared types and constants of the line rasterizer
package lrast_pkg;

  // coordinate and field widths
  localparam int CoordBits = 12;
  localparam int DeltaBits = CoordBits + 1;
  localparam int DecBits   = CoordBits + 3;
  localparam int WidthBits = 13;
  localparam int AddrBits  = 24;
  localparam int ColorBits = 32;

  localparam logic [WidthBits-1:0] WidthReset = WidthBits'(1024);

  // input item modes
  localparam logic ModeStart = 1'b0;
  localparam logic ModeStep  = 1'b1;

  // input beat
  typedef struct packed {
    logic                 mode;
    logic [CoordBits-1:0] x_start;
    logic [CoordBits-1:0] y_start;
    logic [CoordBits-1:0] x_end;
    logic [CoordBits-1:0] y_end;
    logic [ColorBits-1:0] color;
  } lrast_in_t;

  // result beat
  typedef struct packed {
    logic [CoordBits-1:0] pixel_x;
    logic [CoordBits-1:0] pixel_y;
    logic [AddrBits-1:0]  pixel_address;
    logic [ColorBits-1:0] pixel_value;
    logic                 last;
  } lrast_out_t;

  // generator set-up derived from the endpoints
  typedef struct packed {
    logic                        active;
    logic                        steep;
    logic                        minor_down;
    logic [CoordBits-1:0]        major_pos;
    logic [CoordBits-1:0]        major_stop;
    logic [CoordBits-1:0]        minor_pos;
    logic signed [DecBits-1:0]   decision;
    logic [DeltaBits-1:0]        twice_minor;
    logic [DeltaBits-1:0]        twice_major;
  } lrast_setup_t;

endpackage

// ===== hdl/lrast_setup.sv =====
// line set-up: octant choice, endpoint swap and initial decision term
module lrast_setup (
  input  logic [lrast_pkg::CoordBits-1:0] x_start,
  input  logic [lrast_pkg::CoordBits-1:0] y_start,
  input  logic [lrast_pkg::CoordBits-1:0] x_end,
  input  logic [lrast_pkg::CoordBits-1:0] y_end,
  output lrast_pkg::lrast_setup_t         setup
);

  logic [lrast_pkg::CoordBits-1:0] adx;
  logic [lrast_pkg::CoordBits-1:0] ady;
  logic [lrast_pkg::CoordBits-1:0] d_major;
  logic [lrast_pkg::CoordBits-1:0] d_minor;
  logic [lrast_pkg::CoordBits-1:0] maj0;
  logic [lrast_pkg::CoordBits-1:0] maj1;
  logic [lrast_pkg::CoordBits-1:0] min0;
  logic [lrast_pkg::CoordBits-1:0] min1;
  logic                            steep;

  // absolute deltas
  assign adx = (x_end >= x_start) ? (x_end - x_start) : (x_start - x_end);
  assign ady = (y_end >= y_start) ? (y_end - y_start) : (y_start - y_end);

  // steep when |dy| is not below |dx|
  assign steep = !(ady < adx);

  // order the endpoints so the major axis increases
  always_comb begin
    if (!steep) begin
      if (x_start > x_end) begin
        maj0 = x_end;
        maj1 = x_start;
        min0 = y_end;
        min1 = y_start;
      end else begin
        maj0 = x_start;
        maj1 = x_end;
        min0 = y_start;
        min1 = y_end;
      end
    end else begin
      if (y_start > y_end) begin
        maj0 = y_end;
        maj1 = y_start;
        min0 = x_end;
        min1 = x_start;
      end else begin
        maj0 = y_start;
        maj1 = y_end;
        min0 = x_start;
        min1 = x_end;
      end
    end
  end

  assign d_major = steep ? ady : adx;
  assign d_minor = steep ? adx : ady;

  // pack the set-up, decision starts at 2*dminor - dmajor
  always_comb begin
    setup.active      = (maj0 != maj1);
    setup.steep       = steep;
    setup.minor_down  = (min1 < min0);
    setup.major_pos   = maj0;
    setup.major_stop  = maj1;
    setup.minor_pos   = min0;
    setup.twice_minor = {d_minor, 1'b0};
    setup.twice_major = {d_major, 1'b0};
    setup.decision    = $signed({2'b00, d_minor, 1'b0}) - $signed({3'b000, d_major});
  end

endmodule

// ===== hdl/line_rasterizer_core.sv =====
// Bresenham line generator: each accepted step beat gives its pixel beat in the cycle after.
// One input beat per cycle while no held pixel is blocked; one add and compare for the decision term and
// one 12x13 multiply-add for the address sit between the state and the result register.
// Start beats and steps while idle give no pixel. Synchronous active-low reset clears
// the line-in-progress flag and the result valid, and sets the surface width to 1024.
module line_rasterizer_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  lrast_pkg::lrast_in_t              in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output lrast_pkg::lrast_out_t             out_data,
  input  logic                              cfg_wr_en,
  input  logic [lrast_pkg::WidthBits-1:0]   cfg_wr_data
);

  localparam int ProdBits = lrast_pkg::CoordBits + lrast_pkg::WidthBits + 1;

  logic [lrast_pkg::WidthBits-1:0]        surface_width_r;
  logic                                   active_r, active_nxt;
  logic                                   steep_r, steep_nxt;
  logic                                   minor_down_r, minor_down_nxt;
  logic [lrast_pkg::CoordBits-1:0]        major_pos_r, major_pos_nxt;
  logic [lrast_pkg::CoordBits-1:0]        major_stop_r, major_stop_nxt;
  logic [lrast_pkg::CoordBits-1:0]        minor_pos_r, minor_pos_nxt;
  logic signed [lrast_pkg::DecBits-1:0]   decision_r, decision_nxt;
  logic [lrast_pkg::DeltaBits-1:0]        twice_minor_r, twice_minor_nxt;
  logic [lrast_pkg::DeltaBits-1:0]        twice_major_r, twice_major_nxt;
  logic [lrast_pkg::ColorBits-1:0]        line_color_r, line_color_nxt;
  logic                                   out_valid_r, out_valid_nxt;
  lrast_pkg::lrast_out_t                  out_data_r, out_data_nxt;

  lrast_pkg::lrast_setup_t                setup;
  logic                                   in_accept;
  logic                                   emit;
  logic [lrast_pkg::CoordBits-1:0]        px;
  logic [lrast_pkg::CoordBits-1:0]        py;
  logic                                   is_last;
  logic [ProdBits-1:0]                    addr_sum;

  // line set-up from the endpoints of the beat
  lrast_setup u_setup (
    .x_start (in_data.x_start),
    .y_start (in_data.y_start),
    .x_end   (in_data.x_end),
    .y_end   (in_data.y_end),
    .setup   (setup)
  );

  // handshake: take a beat unless a held pixel is blocked
  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign emit      = in_accept && (in_data.mode == lrast_pkg::ModeStep) && active_r;

  // current pixel
  assign px       = steep_r ? minor_pos_r : major_pos_r;
  assign py       = steep_r ? major_pos_r : minor_pos_r;
  assign is_last  = (major_pos_r + lrast_pkg::CoordBits'(1)) == major_stop_r;
  assign addr_sum = ProdBits'(py) * ProdBits'(surface_width_r) + ProdBits'(px);

  // next generator state
  always_comb begin
    active_nxt      = active_r;
    steep_nxt       = steep_r;
    minor_down_nxt  = minor_down_r;
    major_pos_nxt   = major_pos_r;
    major_stop_nxt  = major_stop_r;
    minor_pos_nxt   = minor_pos_r;
    decision_nxt    = decision_r;
    twice_minor_nxt = twice_minor_r;
    twice_major_nxt = twice_major_r;
    line_color_nxt  = line_color_r;
    if (in_accept && (in_data.mode == lrast_pkg::ModeStart)) begin
      active_nxt      = setup.active;
      steep_nxt       = setup.steep;
      minor_down_nxt  = setup.minor_down;
      major_pos_nxt   = setup.major_pos;
      major_stop_nxt  = setup.major_stop;
      minor_pos_nxt   = setup.minor_pos;
      decision_nxt    = setup.decision;
      twice_minor_nxt = setup.twice_minor;
      twice_major_nxt = setup.twice_major;
      line_color_nxt  = in_data.color;
    end else if (emit) begin
      if (decision_r > 0) begin
        minor_pos_nxt = minor_down_r ? (minor_pos_r - lrast_pkg::CoordBits'(1))
                                     : (minor_pos_r + lrast_pkg::CoordBits'(1));
        decision_nxt  = decision_r - $signed({2'b00, twice_major_r})
                                   + $signed({2'b00, twice_minor_r});
      end else begin
        decision_nxt  = decision_r + $signed({2'b00, twice_minor_r});
      end
      major_pos_nxt = major_pos_r + lrast_pkg::CoordBits'(1);
      if (is_last) begin
        active_nxt = 1'b0;
      end
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (emit) begin
      out_valid_nxt              = 1'b1;
      out_data_nxt.pixel_x       = px;
      out_data_nxt.pixel_y       = py;
      out_data_nxt.pixel_address = lrast_pkg::AddrBits'(addr_sum);
      out_data_nxt.pixel_value   = line_color_r;
      out_data_nxt.last          = is_last;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r        <= 1'b0;
      out_valid_r     <= 1'b0;
      surface_width_r <= lrast_pkg::WidthReset;
    end else begin
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        surface_width_r <= cfg_wr_data;
      end
    end
  end

  // datapath state
  always_ff @(posedge clk) begin
    steep_r       <= steep_nxt;
    minor_down_r  <= minor_down_nxt;
    major_pos_r   <= major_pos_nxt;
    major_stop_r  <= major_stop_nxt;
    minor_pos_r   <= minor_pos_nxt;
    decision_r    <= decision_nxt;
    twice_minor_r <= twice_minor_nxt;
    twice_major_r <= twice_major_nxt;
    line_color_r  <= line_color_nxt;
    out_data_r    <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a new pixel beat only follows an accepted step
  a_pixel_from_step: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_accept && (in_data.mode == lrast_pkg::ModeStep)))
    else $error("pixel beat without an accepted step");

  // the final pixel ends the line
  a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && is_last && !(in_accept && (in_data.mode == lrast_pkg::ModeStart))) |=> !active_r)
    else $error("line still active after its last pixel");

  // a start with equal endpoints leaves the generator idle
  a_zero_length_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && (in_data.mode == lrast_pkg::ModeStart) &&
     (in_data.x_start == in_data.x_end) && (in_data.y_start == in_data.y_end)) |=> !active_r)
    else $error("zero-length line left generator active");

endmodule

// ===== tb/sv/line_rasterizer_core_test.sv =====
// testbench of the line rasterizer core: pixel scoreboard and randomised beat traffic
module line_rasterizer_core_test;

  // scoreboard: tracks the generator state and holds the pixels still to come
  class pixel_tracker;
    logic [lrast_pkg::WidthBits-1:0] width_reg;
    bit                              running;
    bit                              steep;
    bit                              minor_down;
    logic [lrast_pkg::CoordBits-1:0] major_pos;
    logic [lrast_pkg::CoordBits-1:0] major_stop;
    logic [lrast_pkg::CoordBits-1:0] minor_pos;
    int                              decision;
    int                              twice_minor;
    int                              twice_major;
    logic [lrast_pkg::ColorBits-1:0] colour;
    lrast_pkg::lrast_out_t           expected_pixels[$];
    int                              failures;

    function new();
      width_reg   = lrast_pkg::WidthReset;
      running     = 1'b0;
      steep       = 1'b0;
      minor_down  = 1'b0;
      major_pos   = '0;
      major_stop  = '0;
      minor_pos   = '0;
      decision    = 0;
      twice_minor = 0;
      twice_major = 0;
      colour      = '0;
      failures    = 0;
    endfunction

    // note an accepted input beat and queue the pixel it gives, if any
    function void take_input(lrast_pkg::lrast_in_t beat);
      int xa, ya, xb, yb, adx, ady, maj0, maj1, min0, min1;
      lrast_pkg::lrast_out_t pix;
      bit ends;
      if (beat.mode == lrast_pkg::ModeStart) begin
        colour = beat.color;
        xa = beat.x_start;
        ya = beat.y_start;
        xb = beat.x_end;
        yb = beat.y_end;
        adx = (xb > xa) ? xb - xa : xa - xb;
        ady = (yb > ya) ? yb - ya : ya - yb;
        // equal deltas fall to the steep case
        steep = !(ady < adx);
        if (!steep) begin
          if (xa > xb) begin
            maj0 = xb; maj1 = xa; min0 = yb; min1 = ya;
          end else begin
            maj0 = xa; maj1 = xb; min0 = ya; min1 = yb;
          end
        end else begin
          if (ya > yb) begin
            maj0 = yb; maj1 = ya; min0 = xb; min1 = xa;
          end else begin
            maj0 = ya; maj1 = yb; min0 = xa; min1 = xb;
          end
        end
        minor_down  = min1 < min0;
        major_pos   = lrast_pkg::CoordBits'(maj0);
        major_stop  = lrast_pkg::CoordBits'(maj1);
        minor_pos   = lrast_pkg::CoordBits'(min0);
        twice_major = 2 * (maj1 - maj0);
        twice_minor = 2 * (minor_down ? min0 - min1 : min1 - min0);
        decision    = twice_minor - twice_major / 2;
        running     = maj0 != maj1;
        return;
      end
      // a step with no line in progress is dropped
      if (!running) return;
      ends = lrast_pkg::CoordBits'(major_pos + 1) == major_stop;
      pix.pixel_x       = steep ? minor_pos : major_pos;
      pix.pixel_y       = steep ? major_pos : minor_pos;
      pix.pixel_address = lrast_pkg::AddrBits'(longint'(pix.pixel_y) * longint'(width_reg)
                                               + longint'(pix.pixel_x));
      pix.pixel_value   = colour;
      pix.last          = ends;
      expected_pixels.push_back(pix);
      // decision term update
      if (decision > 0) begin
        minor_pos = minor_down ? minor_pos - 1'b1 : minor_pos + 1'b1;
        decision -= twice_major;
      end
      decision += twice_minor;
      major_pos = major_pos + 1'b1;
      if (ends) running = 1'b0;
    endfunction

    // compare a delivered pixel beat with the oldest one queued
    function void check_pixel(lrast_pkg::lrast_out_t got);
      lrast_pkg::lrast_out_t want;
      if (expected_pixels.size() == 0) begin
        $error("unexpected pixel beat: x %0d y %0d", got.pixel_x, got.pixel_y);
        failures++;
        return;
      end
      want = expected_pixels.pop_front();
      if (got.pixel_x !== want.pixel_x) begin
        $error("pixel_x: expected %0d, got %0d", want.pixel_x, got.pixel_x);
        failures++;
      end
      if (got.pixel_y !== want.pixel_y) begin
        $error("pixel_y: expected %0d, got %0d", want.pixel_y, got.pixel_y);
        failures++;
      end
      if (got.pixel_address !== want.pixel_address) begin
        $error("pixel_address: expected %0d, got %0d", want.pixel_address,
               got.pixel_address);
        failures++;
      end
      if (got.pixel_value !== want.pixel_value) begin
        $error("pixel_value: expected %0h, got %0h", want.pixel_value, got.pixel_value);
        failures++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, got.last);
        failures++;
      end
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  lrast_pkg::lrast_in_t            in_data = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  lrast_pkg::lrast_out_t           out_data;
  logic                            cfg_wr_en = 1'b0;
  logic [lrast_pkg::WidthBits-1:0] cfg_wr_data = '0;

  pixel_tracker tracker = new();
  bit           send_calm = 1'b0;
  bit           recv_calm = 1'b0;

  line_rasterizer_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #4 clk = ~clk;

  // gap length: mostly none or short, now and then long, none at all in calm stretches
  function automatic int idle_length(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic lrast_pkg::lrast_in_t make_beat(logic mode, int xs, int ys, int xe,
                                                     int ye,
                                                     logic [lrast_pkg::ColorBits-1:0] col);
    lrast_pkg::lrast_in_t beat;
    beat.mode    = mode;
    beat.x_start = lrast_pkg::CoordBits'(xs);
    beat.y_start = lrast_pkg::CoordBits'(ys);
    beat.x_end   = lrast_pkg::CoordBits'(xe);
    beat.y_end   = lrast_pkg::CoordBits'(ye);
    beat.color   = col;
    return beat;
  endfunction

  // result side: random stall runs between short open windows
  initial begin
    int run;
    forever begin
      run = idle_length(recv_calm);
      if (run > 0) begin
        out_stall <= 1'b1;
        repeat (run) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      if ($urandom_range(0, 39) == 0) recv_calm = !recv_calm;
    end
  end

  // check every pixel beat taken
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall == 1'b0)
      tracker.check_pixel(out_data);
  end

  // offer one input beat after a random gap and wait until it is taken
  task automatic push_beat(lrast_pkg::lrast_in_t beat);
    int gap;
    gap = idle_length(send_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (in_stall !== 1'b0);
    tracker.take_input(beat);
    if ($urandom_range(0, 59) == 0) send_calm = !send_calm;
  endtask

  // step beats carry random junk in the unused fields
  task automatic push_steps(int count);
    repeat (count)
      push_beat(make_beat(lrast_pkg::ModeStep, $urandom, $urandom, $urandom, $urandom,
                          $urandom));
  endtask

  // hold off the sender until every queued pixel has been delivered
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (tracker.expected_pixels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_width(logic [lrast_pkg::WidthBits-1:0] w);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= w;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tracker.width_reg = w;
  endtask

  // hand-picked lines: field extremes, both orientations, swaps and the corner cases
  task automatic run_directed();
    // step with nothing in progress
    push_beat(make_beat(lrast_pkg::ModeStep, 4095, 4095, 4095, 4095, 32'hFFFF_FFFF));
    // zero-length line stays idle
    push_beat(make_beat(lrast_pkg::ModeStart, 5, 5, 5, 5, 32'hFFFF_FFFF));
    push_steps(1);
    // shallow, left to right
    push_beat(make_beat(lrast_pkg::ModeStart, 0, 0, 3, 1, 32'h0000_0000));
    push_steps(3);
    // shallow, endpoints swapped, at the far corner
    push_beat(make_beat(lrast_pkg::ModeStart, 4095, 4095, 4091, 4094, 32'hFFFF_FFFF));
    push_steps(4);
    // equal deltas go steep, minor axis counting down
    push_beat(make_beat(lrast_pkg::ModeStart, 10, 20, 13, 17, 32'h5A5A_A5A5));
    push_steps(3);
    // steep line cut short by a new start
    push_beat(make_beat(lrast_pkg::ModeStart, 0, 4095, 1, 4090, 32'hA5A5_5A5A));
    push_steps(2);
    // single pixel, then a step past the end
    push_beat(make_beat(lrast_pkg::ModeStart, 4095, 0, 4094, 0, 32'h1234_5678));
    push_steps(2);
  endtask

  // mostly whole short lines, some long, cut short or overrun, plus idle noise
  task automatic random_lines(int quota);
    int done, r, x0, y0, x1, y1, reach, len, steps;
    done = 0;
    while (done < quota) begin
      r = $urandom_range(0, 99);
      x0 = $urandom_range(0, 4095);
      y0 = $urandom_range(0, 4095);
      if (r < 4) begin
        push_steps(1);
      end else if (r < 8) begin
        push_beat(make_beat(lrast_pkg::ModeStart, x0, y0, x0, y0, $urandom));
        push_steps($urandom_range(1, 2));
        done++;
      end else begin
        if (r < 12) begin
          x1 = $urandom_range(0, 4095);
          y1 = $urandom_range(0, 4095);
        end else begin
          reach = (r < 15) ? 200 : 12;
          x1 = $urandom_range(0, 2 * reach);
          y1 = $urandom_range(0, 2 * reach);
          x1 = x0 + x1 - reach;
          y1 = y0 + y1 - reach;
          if (x1 < 0 || x1 > 4095) x1 = 2 * x0 - x1;
          if (y1 < 0 || y1 > 4095) y1 = 2 * y0 - y1;
        end
        len = (x1 > x0) ? x1 - x0 : x0 - x1;
        reach = (y1 > y0) ? y1 - y0 : y0 - y1;
        if (reach > len) len = reach;
        r = $urandom_range(0, 9);
        if (r == 0 && len > 1) steps = $urandom_range(1, len - 1);
        else if (r == 1) steps = len + $urandom_range(1, 3);
        else steps = len;
        // far-flung endpoints are mostly abandoned early
        if (len > 400 && $urandom_range(0, 19) != 0) steps = $urandom_range(1, 16);
        push_beat(make_beat(lrast_pkg::ModeStart, x0, y0, x1, y1, $urandom));
        push_steps(steps);
        done += 1 + ((steps < len) ? steps : len);
      end
      if ($urandom_range(0, 49) == 0) wait_drained();
    end
  endtask

  // run limit
  initial begin
    #10_000_000;
    $display("line_rasterizer_core_test failed");
    $finish;
  end

  // main sequence: reset, directed lines, then random phases over several widths
  initial begin
    int widths[6];
    widths[0] = 1;
    widths[1] = 4096;
    widths[2] = 0;
    widths[3] = 8191;
    widths[4] = $urandom_range(2, 4095);
    widths[5] = $urandom_range(0, 8191);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    random_lines(200);
    foreach (widths[i]) begin
      wait_drained();
      write_width(lrast_pkg::WidthBits'(widths[i]));
      random_lines(170);
    end
    wait_drained();
    if (tracker.failures == 0) begin
      $display("line_rasterizer_core_test passed");
    end else begin
      $display("line_rasterizer_core_test failed");
    end
    $finish;
  end

endmodule
